FILE: src/snh_pkg.sv
// Shared types, constants and helpers for the symbol name to NID hash unit.
package snh_pkg;

	localparam int unsigned LEN_CNT_BITS_DEF = 32;
	localparam int unsigned NID_CHARS        = 11;

	localparam logic [31:0] SHA_IV0 = 32'h67452301;
	localparam logic [31:0] SHA_IV1 = 32'hEFCDAB89;
	localparam logic [31:0] SHA_IV2 = 32'h98BADCFE;
	localparam logic [31:0] SHA_IV3 = 32'h10325476;
	localparam logic [31:0] SHA_IV4 = 32'hC3D2E1F0;

	localparam logic [31:0] SHA_K0 = 32'h5A827999;
	localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
	localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
	localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef struct packed {
		logic start;
		logic init;
	} sha_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sha_sts_t;

	function automatic logic [7:0] salt_byte(input logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = 8'h51;
			4'd1:    b = 8'h8d;
			4'd2:    b = 8'h64;
			4'd3:    b = 8'ha6;
			4'd4:    b = 8'h35;
			4'd5:    b = 8'hde;
			4'd6:    b = 8'hd8;
			4'd7:    b = 8'hc1;
			4'd8:    b = 8'he6;
			4'd9:    b = 8'hb0;
			4'd10:   b = 8'h39;
			4'd11:   b = 8'hb1;
			4'd12:   b = 8'hc3;
			4'd13:   b = 8'he5;
			4'd14:   b = 8'h52;
			default: b = 8'h30;
		endcase
		return b;
	endfunction

	// 64-symbol alphabet: A-Z a-z 0-9 + -
	function automatic logic [6:0] nid_ascii(input logic [5:0] idx);
		logic [6:0] c;
		priority if (idx < 6'd26)
			c = 7'h41 + {1'b0, idx};
		else if (idx < 6'd52)
			c = 7'h61 + {1'b0, idx} - 7'd26;
		else if (idx < 6'd62)
			c = 7'h30 + {1'b0, idx} - 7'd52;
		else if (idx == 6'd62)
			c = 7'h2b;
		else
			c = 7'h2d;
		return c;
	endfunction

	// digest bytes: d0..d3 = word 1 low to high, d4..d7 = word 0 low to high
	function automatic logic [5:0] nid_index(input logic [31:0] h0, input logic [31:0] h1,
						 input logic [3:0] ci);
		logic [7:0] d0, d1, d2, d3, d4, d5, d6, d7;
		logic [5:0] ix;
		d0 = h1[7:0];   d1 = h1[15:8];  d2 = h1[23:16]; d3 = h1[31:24];
		d4 = h0[7:0];   d5 = h0[15:8];  d6 = h0[23:16]; d7 = h0[31:24];
		unique case (ci)
			4'd0:    ix = d0[7:2];
			4'd1:    ix = {d0[1:0], d1[7:4]};
			4'd2:    ix = {d1[3:0], d2[7:6]};
			4'd3:    ix = d2[5:0];
			4'd4:    ix = d3[7:2];
			4'd5:    ix = {d3[1:0], d4[7:4]};
			4'd6:    ix = {d4[3:0], d5[7:6]};
			4'd7:    ix = d5[5:0];
			4'd8:    ix = d6[7:2];
			4'd9:    ix = {d6[1:0], d7[7:4]};
			default: ix = {d7[3:0], 2'b00};
		endcase
		return ix;
	endfunction

endpackage

FILE: src/snh_sha1_core.sv
// Iterative SHA-1 compression: one round per cycle over a rolling 16-word schedule.
module snh_sha1_core (
	input  logic              clk,
	input  logic              arst_n,
	input  snh_pkg::sha_ctl_t ctl,
	input  logic [511:0]      blk,
	output snh_pkg::sha_sts_t sts,
	output logic [31:0]       h0,
	output logic [31:0]       h1
);
	import snh_pkg::*;

	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];
	logic [6:0]  rnd_q;
	logic        busy_q, fin_q, done_q;
	logic [31:0] f, k, t, w_new;

	always_comb begin
		priority if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = SHA_K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = SHA_K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = SHA_K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = SHA_K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_new[30:0], w_new[31]};
	end

	// schedule and working words carry no reset
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
			for (int i = 0; i < 16; i++)
				w_q[i] <= blk[511 - 32 * i -: 32];
		end else if (busy_q) begin
			a_q <= t; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]}; d_q <= c_q; e_q <= d_q;
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
			h_q[0] <= SHA_IV0; h_q[1] <= SHA_IV1; h_q[2] <= SHA_IV2;
			h_q[3] <= SHA_IV3; h_q[4] <= SHA_IV4;
		end else begin
			done_q <= fin_q;
			if (ctl.init) begin
				h_q[0] <= SHA_IV0; h_q[1] <= SHA_IV1; h_q[2] <= SHA_IV2;
				h_q[3] <= SHA_IV3; h_q[4] <= SHA_IV4;
			end else if (fin_q) begin
				h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
			end
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				if (rnd_q == 7'd79) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					rnd_q <= rnd_q + 7'd1;
				end
			end
			if (fin_q)
				fin_q <= 1'b0;
		end
	end

	assign sts.busy = busy_q | fin_q;
	assign sts.done = done_q;
	assign h0 = h_q[0];
	assign h1 = h_q[1];

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q && !fin_q) else $error("start while compressing");
	a_fin_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fin_q) |-> $past(rnd_q) == 7'd79) else $error("early finish");
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(fin_q)) else $error("done without add");

endmodule

FILE: src/symbol_name_to_nid_hash_unit.sv
// Top level: symbol name bytes in, 11-character SHA-1 based identifier out.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  input   | in_valid / in_stall | name_byte[7:0], is_last
//  output  | out_valid/out_stall | nid_char[6:0], char_last, length_overflow
//
// A name byte is taken only in the idle state. Each full 64-byte block
// costs a load step, 80 rounds, an add step and a hand-back step of the
// shared round unit, with in_stall high. After the last byte the salt,
// padding and length are fed one byte a cycle, pausing while a block is
// compressed, then 11 characters are offered, one per output transfer.
// Reset (arst_n low) restores the chain words and clears count and flag;
// out_stall only holds the current character, nothing is dropped.
module symbol_name_to_nid_hash_unit #(
	parameter int unsigned LENGTH_COUNTER_BITS = snh_pkg::LEN_CNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] name_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] nid_char,
	output logic       char_last,
	output logic       length_overflow
);
	import snh_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SFX  = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_COMP = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		PH_SALT = 3'b001,
		PH_PAD  = 3'b010,
		PH_LEN  = 3'b100
	} phase_t;

	state_t    state_q;
	phase_t    phase_q;
	logic [511:0] buf_q;           // block buffer, first byte ends at the top
	logic [5:0]   fill_q;
	logic [LENGTH_COUNTER_BITS-1:0] cnt_q;
	logic         ovf_q;
	logic         fin_q;           // last name byte taken, suffix pending
	logic         all_q;           // final length byte absorbed
	logic [4:0]   sidx_q;
	logic [2:0]   lidx_q;
	logic [3:0]   ci_q;

	sha_ctl_t    ctl;
	sha_sts_t    sts;
	logic [31:0] h0, h1;

	logic        in_xfer, out_xfer;
	logic        absorb;
	logic [7:0]  abs_byte;
	logic [63:0] bit_len, len_sh;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);

	// message length in bits including the 16 salt bytes, modulo 2^64
	assign bit_len = ({{(64-LENGTH_COUNTER_BITS){1'b0}}, cnt_q} + 64'd16) << 3;
	assign len_sh  = bit_len << {lidx_q, 3'b000};

	always_comb begin
		absorb   = 1'b0;
		abs_byte = 8'h00;
		unique case (state_q)
			ST_IDLE: begin
				absorb   = in_valid;
				abs_byte = name_byte;
			end
			ST_SFX: begin
				unique case (phase_q)
					PH_SALT: begin
						absorb   = 1'b1;
						abs_byte = sidx_q[4] ? PAD_BYTE : salt_byte(sidx_q[3:0]);
					end
					PH_PAD: begin
						absorb   = (fill_q != 6'd56);
						abs_byte = 8'h00;
					end
					default: begin
						absorb   = 1'b1;
						abs_byte = len_sh[63:56];
					end
				endcase
			end
			default: begin
				absorb   = 1'b0;
				abs_byte = 8'h00;
			end
		endcase
		ctl.start = (state_q == ST_LOAD);
		ctl.init  = out_xfer && (ci_q == 4'(NID_CHARS - 1));
	end

	always_ff @(posedge clk) begin
		if (absorb)
			buf_q <= {buf_q[503:0], abs_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_SALT;
			fill_q  <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			fin_q   <= 1'b0;
			all_q   <= 1'b0;
			sidx_q  <= '0;
			lidx_q  <= '0;
			ci_q    <= '0;
		end else begin
			if (absorb)
				fill_q <= fill_q + 6'd1;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (&cnt_q)
							ovf_q <= 1'b1;
						else
							cnt_q <= cnt_q + 1'b1;
						if (is_last) begin
							fin_q   <= 1'b1;
							phase_q <= PH_SALT;
							sidx_q  <= '0;
							lidx_q  <= '0;
						end
						if (fill_q == 6'd63)
							state_q <= ST_LOAD;
						else if (is_last)
							state_q <= ST_SFX;
					end
				end
				ST_SFX: begin
					unique case (phase_q)
						PH_SALT: begin
							sidx_q <= sidx_q + 5'd1;
							if (sidx_q[4])
								phase_q <= PH_PAD;
						end
						PH_PAD: begin
							if (fill_q == 6'd56)
								phase_q <= PH_LEN;
						end
						default: begin
							lidx_q <= lidx_q + 3'd1;
							if (lidx_q == 3'd7)
								all_q <= 1'b1;
						end
					endcase
					if (absorb && fill_q == 6'd63)
						state_q <= ST_LOAD;
				end
				ST_LOAD: state_q <= ST_COMP;
				ST_COMP: begin
					if (sts.done) begin
						if (all_q)
							state_q <= ST_EMIT;
						else if (fin_q)
							state_q <= ST_SFX;
						else
							state_q <= ST_IDLE;
					end
				end
				default: begin
					if (out_xfer) begin
						if (ci_q == 4'(NID_CHARS - 1)) begin
							ci_q    <= '0;
							state_q <= ST_IDLE;
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							fin_q   <= 1'b0;
							all_q   <= 1'b0;
						end else begin
							ci_q <= ci_q + 4'd1;
						end
					end
				end
			endcase
		end
	end

	snh_sha1_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.blk    (buf_q),
		.sts    (sts),
		.h0     (h0),
		.h1     (h1)
	);

	assign nid_char        = nid_ascii(nid_index(h0, h1, ci_q));
	assign char_last       = (ci_q == 4'(NID_CHARS - 1));
	assign length_overflow = ovf_q;

	a_emit_block_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> fill_q == 6'd0 && !sts.busy) else $error("emit mid-block");
	a_comp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> sts.busy) else $error("core not started");
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && char_last |=> state_q == ST_IDLE && !ovf_q) else $error("no clear");
	a_no_input_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> in_stall) else $error("input taken while compressing");

endmodule

FILE: tb/nid_hash_checker.sv
`timescale 1ns / 100ps
// Checker: watches both channels, predicts the identifier characters and compares them.
module nid_hash_checker #(
	parameter int unsigned LENGTH_COUNTER_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] name_byte,
	input  logic       is_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [6:0] nid_char,
	input  logic       char_last,
	input  logic       length_overflow,
	output int         fail_count,
	output int         chars_due
);

	typedef struct packed {
		logic [6:0] ch;
		logic       fin;
		logic       ovf;
	} nid_char_t;

	localparam logic [127:0] SUFFIX = 128'h518d64a635ded8c1e6b039b1c3e55230;
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+-";
	localparam longint unsigned COUNT_MAX = (64'd1 << LENGTH_COUNTER_BITS) - 64'd1;

	logic [31:0]     chain [5];
	logic [7:0]      blk [64];
	int              fill;
	longint unsigned name_len;
	logic            sat;
	nid_char_t       due_q [$];

	assign chars_due = due_q.size();

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rotl(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
	endfunction

	function automatic void absorb(input logic [7:0] v);
		blk[fill] = v;
		fill++;
		if (fill == 64) begin
			compress();
			fill = 0;
		end
	endfunction

	function automatic void clear_hash();
		chain[0] = 32'h67452301; chain[1] = 32'hEFCDAB89; chain[2] = 32'h98BADCFE;
		chain[3] = 32'h10325476; chain[4] = 32'hC3D2E1F0;
		fill = 0; name_len = 0; sat = 1'b0;
	endfunction

	// finish the digest and queue the 11 characters
	function automatic void finish_name();
		logic [63:0] bits;
		logic [7:0]  d [8];
		logic [5:0]  ix [11];
		nid_char_t   r;
		for (int i = 0; i < 16; i++)
			absorb(SUFFIX[8*(15-i) +: 8]);
		bits = (name_len + 64'd16) * 64'd8;
		absorb(8'h80);
		while (fill != 56)
			absorb(8'h00);
		for (int i = 0; i < 8; i++)
			absorb(bits[8*(7-i) +: 8]);
		for (int i = 0; i < 4; i++) begin
			d[i]   = chain[1][8*i +: 8];
			d[4+i] = chain[0][8*i +: 8];
		end
		for (int g = 0; g < 2; g++) begin
			ix[4*g]   = d[3*g][7:2];
			ix[4*g+1] = {d[3*g][1:0], d[3*g+1][7:4]};
			ix[4*g+2] = {d[3*g+1][3:0], d[3*g+2][7:6]};
			ix[4*g+3] = d[3*g+2][5:0];
		end
		ix[8]  = d[6][7:2];
		ix[9]  = {d[6][1:0], d[7][7:4]};
		ix[10] = {d[7][3:0], 2'b00};
		for (int i = 0; i < 11; i++) begin
			r.ch  = ALPHABET[8*(63-ix[i]) +: 7];
			r.fin = (i == 10);
			r.ovf = sat;
			due_q.insert(due_q.size(), r);
		end
		clear_hash();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		nid_char_t want;
		int        errs;
		if (!arst_n) begin
			clear_hash();
			due_q.delete();
			fail_count <= 0;
		end else begin
			errs = 0;
			if (in_valid && !in_stall) begin
				if (name_len >= COUNT_MAX) begin
					name_len = COUNT_MAX;
					sat = 1'b1;
				end else
					name_len++;
				absorb(name_byte);
				if (is_last)
					finish_name();
			end
			if (out_valid && !out_stall) begin
				if (due_q.size() == 0) begin
					$error("unexpected character transfer: %h", nid_char);
					errs++;
				end else begin
					want = due_q.pop_front();
					if (nid_char !== want.ch) begin
						$error("nid_char: expected %h, got %h", want.ch, nid_char);
						errs++;
					end
					if (char_last !== want.fin) begin
						$error("char_last: expected %b, got %b", want.fin, char_last);
						errs++;
					end
					if (length_overflow !== want.ovf) begin
						$error("length_overflow: expected %b, got %b",
							want.ovf, length_overflow);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

FILE: tb/tb_symbol_name_to_nid_hash_unit.sv
`timescale 1ns / 100ps
// Testbench top: drives symbol names into the hash unit and reports the verdict.
module tb_symbol_name_to_nid_hash_unit;

	// length counter width under test
	localparam int unsigned CNT_BITS = 16;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] name_byte;
	logic       is_last;
	logic       out_valid;
	logic       out_stall;
	logic [6:0] nid_char;
	logic       char_last;
	logic       length_overflow;
	int         fail_count;
	int         chars_due;

	// sender burst state
	int         burst_left;
	bit         gaps_on;
	// receiver long hold request
	bit         hold_req;
	int         rand_bytes;

	symbol_name_to_nid_hash_unit #(.LENGTH_COUNTER_BITS(CNT_BITS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.name_byte(name_byte), .is_last(is_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.nid_char(nid_char), .char_last(char_last), .length_overflow(length_overflow)
	);

	nid_hash_checker #(.LENGTH_COUNTER_BITS(CNT_BITS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.name_byte(name_byte), .is_last(is_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.nid_char(nid_char), .char_last(char_last), .length_overflow(length_overflow),
		.fail_count(fail_count), .chars_due(chars_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: stall mode redrawn on a tick count; a requested hold is counted here.
	initial begin
		int mode, hold_cnt, tick;
		out_stall = 1'b0;
		mode = 0; hold_cnt = 0; tick = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 400;
			end
			if (tick % 64 == 0)
				mode = $urandom_range(0, 3);
			tick++;
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall = 1'b1;
			end else case (mode)
				0:       out_stall = 1'b0;
				1:       out_stall = ($urandom_range(0, 9) < 3);
				2:       out_stall = ($urandom_range(0, 9) < 8);
				default: out_stall = ((tick / 3) % 2 == 1);
			endcase
		end
	end

	// One byte transfer; gaps between bursts fall before the byte is offered.
	task automatic push_byte(input logic [7:0] v, input logic fin);
		if (gaps_on && burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid  = 1'b1;
		name_byte = v;
		is_last   = fin;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Name of the given length; pattern 0 random, 1 all zero, 2 all ones.
	task automatic push_name(input int len, input int pat);
		logic [7:0] v;
		for (int i = 0; i < len; i++) begin
			case (pat)
				1:       v = 8'h00;
				2:       v = 8'hFF;
				default: v = $urandom_range(0, 255);
			endcase
			push_byte(v, i == len - 1);
		end
	endtask

	task automatic drain();
		while (chars_due != 0)
			@(negedge clk);
	endtask

	initial begin
		int len;
		arst_n = 1'b0; in_valid = 1'b0; name_byte = 8'h00; is_last = 1'b0;
		hold_req = 1'b0; burst_left = 0; gaps_on = 1'b1; rand_bytes = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extreme bytes, short names, padding boundaries
		push_name(1, 1);
		push_name(1, 2);
		push_name(3, 0);
		drain();
		// 39 bytes fit one block with suffix and length, 40 need a second
		push_name(39, 0);
		push_name(40, 2);
		drain();

		// long receiver hold while names keep coming: block backs up and stalls input
		hold_req = 1'b1;
		for (int n = 0; n < 4; n++)
			push_name($urandom_range(1, 6), 0);
		drain();

		// random short names
		while (rand_bytes < 30) begin
			len = $urandom_range(1, 12);
			gaps_on = ($urandom_range(0, 3) != 0);
			push_name(len, 0);
			rand_bytes += len;
			if ($urandom_range(0, 4) == 0)
				drain();
		end

		drain();
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
